@@ rtl/vprt_pkg.sv @@
// Shared types and constants for the video port and raster timing unit.
package vprt_pkg;

	localparam int VRAM_ADDR_BITS = 14;

	localparam logic [1:0] REQ_READ    = 2'd0;
	localparam logic [1:0] REQ_WRITE   = 2'd1;
	localparam logic [1:0] REQ_ADVANCE = 2'd2;
	localparam logic [1:0] REQ_UNUSED  = 2'd3;

	localparam logic [7:0] PORT_DATA = 8'hBE;
	localparam logic [7:0] PORT_CTRL = 8'hBF;
	localparam logic [7:0] PORT_VCNT = 8'h7E;
	localparam logic [7:0] PORT_HCNT = 8'h7F;

	localparam logic [1:0] CODE_PREFETCH = 2'd0;
	localparam logic [1:0] CODE_VRAM     = 2'd1;
	localparam logic [1:0] CODE_REG      = 2'd2;
	localparam logic [1:0] CODE_CRAM     = 2'd3;

	// mode register indexes
	localparam logic [3:0] REG_MODE0       = 4'd0;
	localparam logic [3:0] REG_MODE1       = 4'd1;
	localparam logic [3:0] REG_SCROLL      = 4'd9;
	localparam logic [3:0] REG_LINE_RELOAD = 4'd10;

	localparam logic [10:0] H_LAST      = 11'd684;
	localparam logic [10:0] H_TOTAL     = 11'd685;
	// one advance can carry the count past two line lengths
	localparam logic [10:0] H_TOTAL_X2  = H_TOTAL + H_TOTAL;
	localparam logic [8:0]  V_JUMP_FROM = 9'd218;
	localparam logic [7:0]  V_JUMP_TO   = 8'd212;
	localparam logic [8:0]  V_LAST      = 9'd261;
	localparam logic [8:0]  V_ACTIVE    = 9'd192;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  port;
		logic [7:0]  write_data;
		logic [10:0] cycles;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       interrupt;
		logic       line_ready;
		logic [7:0] line_number;
		logic [7:0] scroll_latch;
	} res_t;

	typedef struct packed {
		logic                      rd;
		logic                      wr;
		logic [VRAM_ADDR_BITS-1:0] addr;
		logic [7:0]                wdata;
	} vram_req_t;

	// Events of one time advance, valid in the cycle the item is taken.
	typedef struct packed {
		logic       line_ready;
		logic [7:0] line_number;
		logic       line_flag_set;
		logic       frame_set;
		logic [7:0] scroll_next;
	} rast_evt_t;

	typedef struct packed {
		logic [7:0] vcount;
		logic [7:0] hcount_lo;
	} rast_cnt_t;

endpackage

@@ rtl/vprt_vram.sv @@
// Video memory: single port synchronous RAM with a clearing sweep after reset.
module vprt_vram (
	input  logic                clk,
	input  logic                arst_n,
	input  vprt_pkg::vram_req_t acc,
	output logic [7:0]          rdata,
	output logic                busy
);
	import vprt_pkg::*;

	localparam int DEPTH = 1 << VRAM_ADDR_BITS;

	logic [7:0]              mem [DEPTH];
	logic [VRAM_ADDR_BITS:0] clr_q;
	logic [7:0]              rdata_q;

	assign busy  = !clr_q[VRAM_ADDR_BITS];
	assign rdata = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			mem[clr_q[VRAM_ADDR_BITS-1:0]] <= '0;
		end else if (acc.wr) begin
			mem[acc.addr] <= acc.wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (!busy && acc.rd) begin
			rdata_q <= mem[acc.addr];
		end
	end

endmodule

@@ rtl/vprt_raster.sv @@
// Raster timing: horizontal counter, scanline, line countdown and scroll latch.
module vprt_raster (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [10:0]         cycles,
	input  logic                disp_en,
	input  logic [7:0]          scroll_reg,
	input  logic [7:0]          count_reg,
	output vprt_pkg::rast_evt_t evt,
	output vprt_pkg::rast_cnt_t cnt
);
	import vprt_pkg::*;

	logic [9:0]  hc_q;
	logic [8:0]  tl_q;
	logic [7:0]  rep_q;
	logic [7:0]  cd_q;
	logic [7:0]  scroll_q;

	logic [10:0] sum;
	logic        wrap;
	logic        line_end;
	logic [9:0]  hc_n;
	logic [8:0]  tl_n;
	logic [7:0]  rep_n;
	logic [7:0]  cd_n;
	logic [7:0]  rep_base;

	always_comb begin
		sum      = {1'b0, hc_q} + {1'b0, cycles[10:1]};
		wrap     = sum > H_LAST;
		line_end = advance && wrap;
		// count modulo line length; sum stays below three line lengths
		hc_n     = (sum >= H_TOTAL_X2) ? 10'(sum - H_TOTAL_X2) :
			(wrap ? 10'(sum - H_TOTAL) : sum[9:0]);

		evt.line_ready    = 1'b0;
		evt.line_number   = '0;
		evt.line_flag_set = 1'b0;
		evt.frame_set     = 1'b0;
		evt.scroll_next   = scroll_q;
		tl_n     = tl_q;
		rep_n    = rep_q;
		cd_n     = cd_q;
		rep_base = (tl_q == V_JUMP_FROM) ? V_JUMP_TO : rep_q;

		if (line_end) begin
			if (tl_q < V_ACTIVE) begin
				evt.line_ready  = disp_en;
				evt.line_number = disp_en ? tl_q[7:0] : 8'd0;
			end else begin
				evt.scroll_next = scroll_reg;
			end
			if (tl_q <= V_ACTIVE) begin
				if (cd_q == 8'd0) begin
					cd_n              = count_reg;
					evt.line_flag_set = 1'b1;
				end else begin
					cd_n = cd_q - 1'b1;
				end
			end else begin
				cd_n = count_reg;
			end
			evt.frame_set = (tl_q == V_ACTIVE);
			if (tl_q == V_LAST) begin
				rep_n = '0;
				tl_n  = '0;
			end else begin
				rep_n = rep_base + 1'b1;
				tl_n  = tl_q + 1'b1;
			end
		end
	end

	assign cnt.vcount    = rep_q;
	assign cnt.hcount_lo = hc_q[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q     <= '0;
			tl_q     <= '0;
			rep_q    <= '0;
			cd_q     <= '0;
			scroll_q <= '0;
		end else if (advance) begin
			hc_q     <= hc_n;
			tl_q     <= tl_n;
			rep_q    <= rep_n;
			cd_q     <= cd_n;
			scroll_q <= evt.scroll_next;
		end
	end

`ifndef SYNTHESIS
	a_hc_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, hc_q} < H_TOTAL)
		else $error("horizontal count out of range");
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		tl_q <= V_LAST)
		else $error("scanline out of range");
	a_line_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		line_end && tl_q == V_LAST |=> tl_q == 9'd0 && rep_q == 8'd0)
		else $error("frame wrap missed");
	a_ready_visible: assert property (@(posedge clk) disable iff (!arst_n)
		evt.line_ready |-> line_end && tl_q < V_ACTIVE)
		else $error("line ready outside visible area");
`endif

endmodule

@@ rtl/video_port_and_raster_timing_unit.sv @@
// Top level: CPU port decode, command/address state and result register.
//
// Usage:
//  - req channel (req_valid/req_stall/req_item) carries one item per CPU port
//    read, port write or advance of video time. It is taken at a clock edge
//    with req_valid high and req_stall low.
//  - res channel (res_valid/res_stall/res_item) returns exactly one item per
//    request, in order, taken when res_valid is high and res_stall is low.
//  - The result is registered and appears in the cycle after the request is
//    taken. Throughput is one item per cycle while req_stall is low: a VRAM
//    prefetch issued by one item is forwarded from the RAM's registered read
//    data to the next item, so no bubble is needed.
//  - req_stall is high while the result register holds an item that the
//    receiver stalls; the request side then waits and all state holds.
//  - After reset the video memory is swept to zero, one entry per cycle, over
//    all 2^VRAM_ADDR_BITS (16384) entries; req_stall stays high meanwhile.
//    Control registers and counters reset to zero asynchronously; the result data register has no reset.
//  - Color memory is not held in this block: data writes aimed at it reach no memory.
module video_port_and_raster_timing_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  vprt_pkg::req_t  req_item,
	output logic            res_valid,
	input  logic            res_stall,
	output vprt_pkg::res_t  res_item
);
	import vprt_pkg::*;

	// port state
	logic [15:0] cmd_q;          // code in [15:14], address in [13:0]
	logic        pend_q;         // first control byte seen
	logic        ctgt_q;         // data writes go to color memory
	logic [7:0]  rb_q;           // read buffer
	logic        rb_pend_q;      // read buffer arrives from RAM this cycle
	logic        frame_q;        // frame flag, mirrors status bit 7
	logic        lflag_q;
	logic [7:0]  mode_q [16];

	logic        res_valid_q;
	res_t        res_q;

	// next-state
	logic [15:0] cmd_n;
	logic        pend_n;
	logic        ctgt_n;
	logic [7:0]  rb_n;
	logic        frame_n;
	logic        lflag_n;
	logic        mode_we;
	logic [3:0]  mode_idx;
	logic [7:0]  rb_eff;
	logic [7:0]  rd;
	logic        r0_ie;
	logic        r1_ie;
	logic        acc;
	logic        advance;

	vram_req_t   vreq;
	logic [7:0]  vram_rdata;
	logic        vram_busy;
	rast_evt_t   evt;
	rast_cnt_t   cnt;

	assign req_stall = vram_busy || (res_valid_q && res_stall);
	assign acc       = req_valid && !req_stall;
	assign advance   = acc && req_item.req_type == REQ_ADVANCE;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// prefetched byte is taken straight from the RAM output the cycle after
	assign rb_eff = rb_pend_q ? vram_rdata : rb_q;

	vprt_vram u_vram (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (vreq),
		.rdata  (vram_rdata),
		.busy   (vram_busy)
	);

	vprt_raster u_raster (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.cycles     (req_item.cycles),
		.disp_en    (mode_q[REG_MODE1][6]),
		.scroll_reg (mode_q[REG_SCROLL]),
		.count_reg  (mode_q[REG_LINE_RELOAD]),
		.evt        (evt),
		.cnt        (cnt)
	);

	always_comb begin
		cmd_n      = cmd_q;
		pend_n     = pend_q;
		ctgt_n     = ctgt_q;
		rb_n       = rb_eff;
		frame_n    = frame_q;
		lflag_n    = lflag_q;
		mode_we    = 1'b0;
		mode_idx   = cmd_q[11:8];
		rd         = '0;
		vreq.rd    = 1'b0;
		vreq.wr    = 1'b0;
		vreq.addr  = cmd_q[VRAM_ADDR_BITS-1:0];
		vreq.wdata = req_item.write_data;

		if (acc) begin
			unique case (req_item.req_type)
				REQ_READ: begin
					priority if (req_item.port == PORT_DATA) begin
						rd      = rb_eff;
						pend_n  = 1'b0;
						vreq.rd = 1'b1;
						cmd_n   = {cmd_q[15:14], cmd_q[13:0] + 14'd1};
					end else if (req_item.port == PORT_CTRL) begin
						rd      = {frame_q, 7'd0};
						pend_n  = 1'b0;
						frame_n = 1'b0;
						lflag_n = 1'b0;
					end else if (req_item.port == PORT_VCNT) begin
						rd = cnt.vcount;
					end else if (req_item.port == PORT_HCNT) begin
						rd = cnt.hcount_lo;
					end else begin
						rd = '0;
					end
				end
				REQ_WRITE: begin
					priority if (req_item.port == PORT_DATA) begin
						rb_n    = req_item.write_data;
						vreq.wr = !ctgt_q;
						cmd_n   = {cmd_q[15:14], cmd_q[13:0] + 14'd1};
					end else if (req_item.port == PORT_CTRL) begin
						if (!pend_q) begin
							cmd_n  = {cmd_q[15:8], req_item.write_data};
							pend_n = 1'b1;
						end else begin
							cmd_n    = {req_item.write_data, cmd_q[7:0]};
							pend_n   = 1'b0;
							mode_idx = req_item.write_data[3:0];
							unique case (req_item.write_data[7:6])
								CODE_PREFETCH: begin
									vreq.rd   = 1'b1;
									vreq.addr = cmd_n[VRAM_ADDR_BITS-1:0];
									cmd_n     = {cmd_n[15:14], cmd_n[13:0] + 14'd1};
								end
								CODE_VRAM: ctgt_n = 1'b0;
								CODE_REG: begin
									ctgt_n  = 1'b0;
									mode_we = 1'b1;
								end
								CODE_CRAM: ctgt_n = 1'b1;
								default: ctgt_n = ctgt_q;
							endcase
						end
					end else begin
						cmd_n = cmd_q;
					end
				end
				REQ_ADVANCE: begin
					lflag_n = lflag_q || evt.line_flag_set;
					frame_n = frame_q || evt.frame_set;
				end
				default: rd = '0;
			endcase
		end

		// interrupt enables as they stand after this item
		r0_ie = (mode_we && mode_idx == REG_MODE0) ? cmd_q[4] : mode_q[REG_MODE0][4];
		r1_ie = (mode_we && mode_idx == REG_MODE1) ? cmd_q[5] : mode_q[REG_MODE1][5];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= '0;
			pend_q    <= 1'b0;
			ctgt_q    <= 1'b0;
			rb_q      <= '0;
			rb_pend_q <= 1'b0;
			frame_q   <= 1'b0;
			lflag_q   <= 1'b0;
			for (int i = 0; i < 16; i++) begin
				mode_q[i] <= '0;
			end
		end else begin
			cmd_q     <= cmd_n;
			pend_q    <= pend_n;
			ctgt_q    <= ctgt_n;
			rb_q      <= rb_n;
			rb_pend_q <= vreq.rd;
			frame_q   <= frame_n;
			lflag_q   <= lflag_n;
			if (mode_we) begin
				mode_q[mode_idx] <= cmd_q[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (acc) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_q.read_data    <= rd;
			res_q.interrupt    <= (lflag_n && r0_ie) || (frame_n && r1_ie);
			res_q.line_ready   <= evt.line_ready;
			res_q.line_number  <= evt.line_number;
			res_q.scroll_latch <= evt.scroll_next;
		end
	end

`ifndef SYNTHESIS
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		vram_busy |-> !acc)
		else $error("item taken during memory clear");
	a_rb_forward: assert property (@(posedge clk) disable iff (!arst_n)
		rb_pend_q |=> !rb_pend_q || $past(acc))
		else $error("prefetch issued without an item");
	a_one_ram_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(vreq.rd && vreq.wr))
		else $error("read and write in one cycle");
`endif

endmodule
